[rtl/pbd_pkg.sv]
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, types and codes for the point-box distance pipeline.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int DIFF_W  = 18;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DIST_W  = 17;
    localparam int REG_W   = 4;
    localparam int N_CELLS = ROOT_W;

    localparam logic [DIFF_W-1:0] DIFF_CLAMP = DIFF_W'(131072);
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam logic [REG_W-1:0] REGION_INSIDE = REG_W'(4);
    localparam logic [REG_W-1:0] REGION_LAST   = REG_W'(8);

    typedef struct packed {
        logic [REG_W-1:0]  region;
        logic [DIFF_W-1:0] gx;
        logic [DIFF_W-1:0] gy;
        logic [DIFF_W-1:0] fx;
        logic [DIFF_W-1:0] fy;
    } front_data_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } lane_t;

    typedef struct packed {
        lane_t            near_lane;
        lane_t            far_lane;
        logic [REG_W-1:0] region;
    } cell_data_t;

endpackage

[rtl/pbd_front.sv]
// ----------------------------------------------------------------------------
// pbd_front
// Region classification, clamped axis gaps and far-corner axis spans.
// ----------------------------------------------------------------------------
module pbd_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [COORD_WIDTH-1:0]   box_left,
    input  logic [COORD_WIDTH-1:0]   box_bottom,
    input  logic [COORD_WIDTH-1:0]   box_right,
    input  logic [COORD_WIDTH-1:0]   box_top,
    input  logic [COORD_WIDTH-1:0]   point_x,
    input  logic [COORD_WIDTH-1:0]   point_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pbd_pkg::front_data_t     out_data
);
    import pbd_pkg::*;

    localparam int DW    = COORD_WIDTH + 2;
    localparam int EXT_W = (DW > DIFF_W) ? DW : DIFF_W;

    logic                 valid_reg;
    front_data_t          data_reg;
    front_data_t          data_next;
    logic [1:0]           col;
    logic [1:0]           row;
    logic [DIFF_W-1:0]    ax;
    logic [DIFF_W-1:0]    bx;
    logic [DIFF_W-1:0]    ay;
    logic [DIFF_W-1:0]    by;

    function automatic logic [DIFF_W-1:0] mag_clamp(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        logic [EXT_W-1:0]     e;
        d = DW'(signed'(a)) - DW'(signed'(b));
        m = d[DW-1] ? DW'(-d) : DW'(d);
        e = EXT_W'(m);
        return (e > EXT_W'(DIFF_CLAMP)) ? DIFF_CLAMP : e[DIFF_W-1:0];
    endfunction

    always_comb
    begin
        ax = mag_clamp(point_x, box_left);
        bx = mag_clamp(point_x, box_right);
        ay = mag_clamp(point_y, box_bottom);
        by = mag_clamp(point_y, box_top);

        if (signed'(point_x) < signed'(box_left))
        begin
            col          = BAND_LOW;
            data_next.gx = ax;
        end
        else if (signed'(point_x) > signed'(box_right))
        begin
            col          = BAND_HIGH;
            data_next.gx = bx;
        end
        else
        begin
            col          = BAND_MID;
            data_next.gx = '0;
        end

        if (signed'(point_y) < signed'(box_bottom))
        begin
            row          = BAND_LOW;
            data_next.gy = ay;
        end
        else if (signed'(point_y) > signed'(box_top))
        begin
            row          = BAND_HIGH;
            data_next.gy = by;
        end
        else
        begin
            row          = BAND_MID;
            data_next.gy = '0;
        end

        data_next.fx     = (ax > bx) ? ax : bx;
        data_next.fy     = (ay > by) ? ay : by;
        data_next.region = REG_W'(row) * REG_W'(3) + REG_W'(col);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/pbd_square.sv]
// ----------------------------------------------------------------------------
// pbd_square
// Squares the axis spans, then sums them into the two root radicands.
// ----------------------------------------------------------------------------
module pbd_square (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  pbd_pkg::front_data_t     in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pbd_pkg::cell_data_t      out_data
);
    import pbd_pkg::*;

    logic               prod_valid_reg;
    logic               prod_ready;
    logic [SQ_W-1:0]    gx2_reg;
    logic [SQ_W-1:0]    gy2_reg;
    logic [SQ_W-1:0]    fx2_reg;
    logic [SQ_W-1:0]    fy2_reg;
    logic [REG_W-1:0]   prod_region_reg;
    logic               sum_valid_reg;
    cell_data_t         sum_reg;
    cell_data_t         sum_next;

    assign prod_ready = !sum_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    always_comb
    begin
        sum_next.near_lane.rad  = gx2_reg + gy2_reg;
        sum_next.near_lane.rem  = '0;
        sum_next.near_lane.root = '0;
        sum_next.far_lane.rad   = fx2_reg + fy2_reg;
        sum_next.far_lane.rem   = '0;
        sum_next.far_lane.root  = '0;
        sum_next.region         = prod_region_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            gx2_reg         <= in_data.gx * in_data.gx;
            gy2_reg         <= in_data.gy * in_data.gy;
            fx2_reg         <= in_data.fx * in_data.fx;
            fy2_reg         <= in_data.fy * in_data.fy;
            prod_region_reg <= in_data.region;
        end
        if (prod_ready && prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

endmodule

[rtl/pbd_root_cell.sv]
// ----------------------------------------------------------------------------
// pbd_root_cell
// One digit step of the integer square root for both lanes.
// ----------------------------------------------------------------------------
module pbd_root_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  pbd_pkg::cell_data_t      in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pbd_pkg::cell_data_t      out_data
);
    import pbd_pkg::*;

    logic        valid_reg;
    cell_data_t  data_reg;
    cell_data_t  data_next;

    function automatic lane_t root_step(input lane_t l);
        lane_t              r;
        logic [REM_W+1:0]   work;
        logic [REM_W+1:0]   trial;
        work  = {l.rem, l.rad[SQ_W-1 -: 2]};
        trial = (REM_W+2)'({l.root, 2'b01});
        r.rad = {l.rad[SQ_W-3:0], 2'b00};
        if (work >= trial)
        begin
            r.rem  = REM_W'(work - trial);
            r.root = {l.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = work[REM_W-1:0];
            r.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        data_next.near_lane = root_step(in_data.near_lane);
        data_next.far_lane  = root_step(in_data.far_lane);
        data_next.region    = in_data.region;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/point_box_min_max_distance.sv]
// ----------------------------------------------------------------------------
// point_box_min_max_distance
// Least and greatest distance from a point to an axis-aligned box, 2-D.
//
// Input channel: in_valid / in_stall with box_left, box_bottom, box_right,
// box_top, point_x, point_y (signed). A transfer happens on a clock edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with near_distance, far_distance
// and region; one result per input transfer, in order.
// Path from input transfer to out_valid: classification, squaring,
// summing, then one root bit per cell through a row of 18 root cells.
// Throughput: one transfer per cycle while out_stall is low; every stage
// holds its own valid bit, so empty slots close up while the output is
// stalled and the input keeps taking transfers until the whole row is full.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module point_box_min_max_distance #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COORD_WIDTH-1:0]        box_left,
    input  logic [COORD_WIDTH-1:0]        box_bottom,
    input  logic [COORD_WIDTH-1:0]        box_right,
    input  logic [COORD_WIDTH-1:0]        box_top,
    input  logic [COORD_WIDTH-1:0]        point_x,
    input  logic [COORD_WIDTH-1:0]        point_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pbd_pkg::DIST_W-1:0]    near_distance,
    output logic [pbd_pkg::DIST_W-1:0]    far_distance,
    output logic [pbd_pkg::REG_W-1:0]     region
);
    import pbd_pkg::*;

    logic         front_ready;
    logic         front_valid;
    front_data_t  front_data;
    logic         sq_ready;

    logic         chain_valid [N_CELLS+1];
    logic         chain_ready [N_CELLS+1];
    cell_data_t   chain_data  [N_CELLS+1];

    cell_data_t   last_data;

    pbd_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (front_ready),
        .box_left   (box_left),
        .box_bottom (box_bottom),
        .box_right  (box_right),
        .box_top    (box_top),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (front_valid),
        .out_ready  (sq_ready),
        .out_data   (front_data)
    );

    pbd_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (sq_ready),
        .in_data   (front_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        pbd_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign chain_ready[N_CELLS] = !out_stall;
    assign in_stall             = !front_ready;
    assign last_data            = chain_data[N_CELLS];
    assign out_valid            = chain_valid[N_CELLS];

    assign near_distance = last_data.near_lane.root[ROOT_W-1] ? DIST_MAX
                         : last_data.near_lane.root[DIST_W-1:0];
    assign far_distance  = last_data.far_lane.root[ROOT_W-1] ? DIST_MAX
                         : last_data.far_lane.root[DIST_W-1:0];
    assign region        = last_data.region;

    a_near_le_far: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> near_distance <= far_distance)
        else $error("near distance exceeds far distance");

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && region == REGION_INSIDE) |-> near_distance == '0)
        else $error("point inside box with non-zero near distance");

    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region <= REGION_LAST)
        else $error("region code out of range");

    a_no_stall_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output flows");

endmodule
